### hdl/lpsm_pkg.sv
package lpsm_pkg;

    localparam logic [1:0] CMD_MIX   = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [5:0]  IDX_HIGHLIGHT = 6'h3e;
    localparam logic [5:0]  IDX_SHADOW    = 6'h3f;
    localparam logic [15:0] WORD_MASK     = 16'h0eee;

    typedef struct packed {
        logic [5:0] index;
        logic       shadow;
        logic       highlight;
    } t_mix;

    function automatic logic [7:0] level(input logic [2:0] code);
        logic [7:0] v;
        unique case (code)
            3'd0: v = 8'd0;
            3'd1: v = 8'd36;
            3'd2: v = 8'd73;
            3'd3: v = 8'd109;
            3'd4: v = 8'd146;
            3'd5: v = 8'd182;
            3'd6: v = 8'd219;
            3'd7: v = 8'd255;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

### hdl/layer_priority_shadow_mixer_top.sv
// Layer mixer: one beat per cycle in, passing through registered stages for layer select,
// color RAM read, and level expansion and shading, with each stage
// stalling only when the stage after it is full. A write beat occupies the RAM stage
// and yields no result; a read beat returns the stored word; unused commands are
// dropped. The 64-entry color RAM does one access per beat and reads as black until
// an entry is written.
module layer_priority_shadow_mixer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_cmd,
    input  logic [5:0]  i_back_color,
    input  logic        i_back_priority,
    input  logic [5:0]  i_front_color,
    input  logic        i_front_priority,
    input  logic [5:0]  i_sprite_color,
    input  logic        i_sprite_priority,
    input  logic [5:0]  i_entry_index,
    input  logic [15:0] i_entry_word,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [5:0]  o_chosen_index,
    output logic        o_is_shadowed,
    output logic        o_is_highlighted,
    output logic [11:0] o_read_word
);

    function automatic logic [7:0] shade(input logic [7:0] v, input logic sh,
                                         input logic hl);
        logic [7:0] r;
        r = v;
        if (sh) begin
            r = {1'b0, v[7:1]};
        end else if (hl) begin
            r = v + {1'b0, ~v[7:1]};
        end
        return r;
    endfunction

    logic [5:0]  r_backdrop;
    logic        r_shade_en;
    logic        cfg_wr;

    logic        in_accept;
    logic        ready2;
    logic        ready3;
    lpsm_pkg::t_mix mix;
    logic [15:0] masked_word;

    logic        r_s1_valid;
    logic        r_s1_is_write;
    logic        r_s1_is_read;
    logic [5:0]  r_s1_addr;
    logic [8:0]  r_s1_wdata;
    logic        r_s1_shadow;
    logic        r_s1_highlight;

    logic [8:0]  r_ram [64];
    logic [63:0] r_ent_vld;

    logic        r_s2_valid;
    logic        r_s2_is_read;
    logic [5:0]  r_s2_index;
    logic        r_s2_shadow;
    logic        r_s2_highlight;
    logic [8:0]  r_s2_ram;
    logic        r_s2_hit;
    logic [8:0]  entry;

    logic        r_s3_valid;
    logic [7:0]  r_s3_red;
    logic [7:0]  r_s3_green;
    logic [7:0]  r_s3_blue;
    logic [5:0]  r_s3_index;
    logic        r_s3_shadow;
    logic        r_s3_highlight;
    logic [11:0] r_s3_read_word;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = paddr[2] ? {31'd0, r_shade_en} : {26'd0, r_backdrop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_backdrop <= 6'd0;
            r_shade_en <= 1'b0;
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                r_shade_en <= pwdata[0];
            end else begin
                r_backdrop <= pwdata[5:0];
            end
        end
    end

    lpsm_mix u_mix (
        .i_backdrop        (r_backdrop),
        .i_shade_en        (r_shade_en),
        .i_back_color      (i_back_color),
        .i_back_priority   (i_back_priority),
        .i_front_color     (i_front_color),
        .i_front_priority  (i_front_priority),
        .i_sprite_color    (i_sprite_color),
        .i_sprite_priority (i_sprite_priority),
        .o_mix             (mix)
    );

    assign ready3     = !r_s3_valid || i_out_ready;
    assign ready2     = !r_s2_valid || ready3;
    assign o_in_ready = !r_s1_valid || ready2;
    assign in_accept  = i_in_valid && o_in_ready;
    assign masked_word = i_entry_word & lpsm_pkg::WORD_MASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= in_accept && (i_cmd == lpsm_pkg::CMD_MIX
                          || i_cmd == lpsm_pkg::CMD_WRITE || i_cmd == lpsm_pkg::CMD_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_s1_is_write  <= (i_cmd == lpsm_pkg::CMD_WRITE);
            r_s1_is_read   <= (i_cmd == lpsm_pkg::CMD_READ);
            r_s1_addr      <= (i_cmd == lpsm_pkg::CMD_MIX) ? mix.index : i_entry_index;
            r_s1_wdata     <= {masked_word[11:9], masked_word[7:5], masked_word[3:1]};
            r_s1_shadow    <= mix.shadow;
            r_s1_highlight <= mix.highlight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready2 && r_s1_valid && r_s1_is_write) begin
            r_ram[r_s1_addr] <= r_s1_wdata;
        end
        if (ready2) begin
            r_s2_ram <= r_ram[r_s1_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld  <= 64'd0;
            r_s2_valid <= 1'b0;
        end else begin
            if (ready2 && r_s1_valid && r_s1_is_write) begin
                r_ent_vld[r_s1_addr] <= 1'b1;
            end
            if (ready2) begin
                r_s2_valid <= r_s1_valid && !r_s1_is_write;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready2) begin
            r_s2_is_read   <= r_s1_is_read;
            r_s2_index     <= r_s1_addr;
            r_s2_shadow    <= r_s1_shadow;
            r_s2_highlight <= r_s1_highlight;
            r_s2_hit       <= r_ent_vld[r_s1_addr];
        end
    end

    assign entry = r_s2_hit ? r_s2_ram : 9'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (ready3) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready3) begin
            if (r_s2_is_read) begin
                r_s3_red       <= 8'd0;
                r_s3_green     <= 8'd0;
                r_s3_blue      <= 8'd0;
                r_s3_index     <= 6'd0;
                r_s3_shadow    <= 1'b0;
                r_s3_highlight <= 1'b0;
                r_s3_read_word <= {entry[8:6], 1'b0, entry[5:3], 1'b0, entry[2:0], 1'b0};
            end else begin
                r_s3_red       <= shade(lpsm_pkg::level(entry[2:0]), r_s2_shadow,
                                        r_s2_highlight);
                r_s3_green     <= shade(lpsm_pkg::level(entry[5:3]), r_s2_shadow,
                                        r_s2_highlight);
                r_s3_blue      <= shade(lpsm_pkg::level(entry[8:6]), r_s2_shadow,
                                        r_s2_highlight);
                r_s3_index     <= r_s2_index;
                r_s3_shadow    <= r_s2_shadow;
                r_s3_highlight <= r_s2_highlight;
                r_s3_read_word <= 12'd0;
            end
        end
    end

    assign o_out_valid      = r_s3_valid;
    assign o_red            = r_s3_red;
    assign o_green          = r_s3_green;
    assign o_blue           = r_s3_blue;
    assign o_chosen_index   = r_s3_index;
    assign o_is_shadowed    = r_s3_shadow;
    assign o_is_highlighted = r_s3_highlight;
    assign o_read_word      = r_s3_read_word;

`ifndef NO_ASSERTIONS
    a_shade_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_is_shadowed && o_is_highlighted))
        else $error("Shadow and highlight are both set on one beat.");

    a_read_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_read_word != 12'd0) |-> (o_red == 8'd0 && o_green == 8'd0
        && o_blue == 8'd0 && o_chosen_index == 6'd0 && !o_is_shadowed))
        else $error("A read result carries pixel fields.");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_is_write && ready2) |=> !r_s2_valid)
        else $error("A write beat reached the output stage.");
`endif

endmodule

### hdl/lpsm_mix.sv
module lpsm_mix (
    input  logic [5:0]          i_backdrop,
    input  logic                i_shade_en,
    input  logic [5:0]          i_back_color,
    input  logic                i_back_priority,
    input  logic [5:0]          i_front_color,
    input  logic                i_front_priority,
    input  logic [5:0]          i_sprite_color,
    input  logic                i_sprite_priority,
    output lpsm_pkg::t_mix      o_mix
);

    logic [5:0] color;
    logic       pri;
    logic       spr;
    logic       lp;
    logic       b_on;
    logic       f_on;
    logic       s_on;

    always_comb begin
        b_on = (i_back_color != 6'd0);
        f_on = (i_front_color != 6'd0);
        s_on = (i_sprite_color != 6'd0);
        color = i_backdrop;
        pri = 1'b0;
        spr = 1'b0;
        lp = 1'b0;
        if (b_on && !i_back_priority) begin
            color = i_back_color; pri = 1'b0; spr = 1'b0;
        end
        if (f_on && !i_front_priority) begin
            color = i_front_color; pri = 1'b0; spr = 1'b0;
        end
        if (s_on && !i_sprite_priority) begin
            color = i_sprite_color; pri = 1'b0; spr = 1'b1;
        end
        if (b_on && i_back_priority) begin
            color = i_back_color; pri = 1'b1; spr = 1'b0;
        end
        if (f_on && i_front_priority) begin
            color = i_front_color; pri = 1'b1; spr = 1'b0;
        end
        if (s_on && i_sprite_priority) begin
            color = i_sprite_color; pri = 1'b1; spr = 1'b1;
        end

        o_mix.shadow = 1'b0;
        o_mix.highlight = 1'b0;
        if (i_shade_en) begin
            o_mix.shadow = !pri;
            if (spr && i_sprite_color == lpsm_pkg::IDX_HIGHLIGHT) begin
                o_mix.highlight = 1'b1;
                o_mix.shadow = 1'b0;
                color = i_backdrop;
                if (b_on) begin
                    color = i_back_color;
                    lp = i_back_priority;
                end
                if (f_on && ((i_front_priority >= lp) || (color == i_backdrop))) begin
                    color = i_front_color;
                end
            end else if (spr && i_sprite_color == lpsm_pkg::IDX_SHADOW) begin
                o_mix.shadow = 1'b1;
                o_mix.highlight = 1'b0;
                color = i_backdrop;
                if (b_on) begin
                    color = i_back_color;
                end
                if (f_on) begin
                    color = i_front_color;
                end
            end
        end
        o_mix.index = color;
    end

endmodule
